// ===== hw/rtl/sfs_pkg.sv =====
// Shared types, command codes and sizes for the sprite frame sequencer.
// No dependencies; every other file refers to it by scoped names.
package sfs_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int MAX_STEPS  = 32;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int COUNT_W    = 7;
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);

    // Input command codes.
    localparam logic [3:0] MODE_TICK    = 4'd0;
    localparam logic [3:0] MODE_PLAY    = 4'd1;
    localparam logic [3:0] MODE_PAUSE   = 4'd2;
    localparam logic [3:0] MODE_RESUME  = 4'd3;
    localparam logic [3:0] MODE_STOP    = 4'd4;
    localparam logic [3:0] MODE_RESET   = 4'd5;
    localparam logic [3:0] MODE_SET     = 4'd6;
    localparam logic [3:0] MODE_NEXT    = 4'd7;
    localparam logic [3:0] MODE_PREV    = 4'd8;
    localparam logic [3:0] MODE_LOAD    = 4'd9;
    localparam logic [3:0] MODE_NEWCLIP = 4'd10;

    // Play states.
    localparam logic [1:0] ST_STOPPED = 2'd0;
    localparam logic [1:0] ST_PLAYING = 2'd1;
    localparam logic [1:0] ST_PAUSED  = 2'd2;

    // Result kinds.
    localparam logic [1:0] EV_STATUS   = 2'd0;
    localparam logic [1:0] EV_CHANGE   = 2'd1;
    localparam logic [1:0] EV_COMPLETE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] CFG_LOOP_ENABLE = 2'd1;
    localparam logic [1:0] CFG_SPEED       = 2'd2;

    localparam logic [8:0] INTERP_ONE = 9'd256;

    typedef struct packed {
        logic [3:0]         mode;
        logic [23:0]        dt_ms;
        logic [5:0]         frame_index;
        logic [23:0]        delay_ms;
        logic               interp_enable;
        logic               keyframe_present;
        logic signed [15:0] keyframe_id;
        logic               sound_present;
        logic [7:0]         sound_id;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [5:0]         old_frame;
        logic [5:0]         new_frame;
        logic               keyframe_fire;
        logic signed [15:0] keyframe_value;
        logic               sound_fire;
        logic [7:0]         sound_number;
        logic [1:0]         play_status;
        logic               interpolating;
        logic [8:0]         interp_factor;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic [23:0]        delay;
        logic               interp;
        logic               kf_on;
        logic signed [15:0] kf_id;
        logic               snd_on;
        logic [7:0]         snd_id;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic rd_tgt;
        logic add;
        logic div_start;
        logic step;
        logic emit_chg;
        logic emit_cmp;
        logic emit_st;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_go;
        logic chg;
        logic loop_go;
        logic complete;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/sprite_frame_sequencer.sv =====
// Sprite frame sequencer, top level: one command word in, one or more result words out.
// A plain command yields its status word; one with a frame change yields a change word first.
// A playing tick advances at most 32 frames;
// the divider runs twice per tick unless the clip completes.
// One word is in work at a time. Reset (aresetn low, synchronous) stops at frame 0.
module sprite_frame_sequencer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sfs_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sfs_pkg::out_word_t m_data,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wr_data
);

    sfs_pkg::cmd_t     cmd;
    sfs_pkg::status_t  status;
    sfs_pkg::in_word_t s_word;
    logic [3:0]        u_dp_mode;
    logic [3:0]        mode_reg;

    assign s_word = s_data;

    // Controller.
    sfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .mode    (u_dp_mode),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath.
    sfs_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_word),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // The latched command code is held from acceptance; the decode cycle follows it.
    always_ff @(posedge aclk) begin
        if (cmd.accept) mode_reg <= s_data.mode;
    end
    assign u_dp_mode = mode_reg;

    // A result word never reports an interpolation factor above one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.interp_factor <= sfs_pkg::INTERP_ONE)
        else $error("interp_factor above one");

    // A completion word always reports the stopped state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.event_kind == sfs_pkg::EV_COMPLETE)
        |-> m_data.play_status == sfs_pkg::ST_STOPPED)
        else $error("complete word while not stopped");

    // Only the status word closes an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.event_kind == sfs_pkg::EV_STATUS)))
        else $error("last flag on a non-status word");

    // An accepted word blocks the input until its work is done.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while busy");

endmodule

// ===== hw/rtl/sfs_div.sv =====
// Iterative divider for the interpolation factor: min(256, num * 256 / den).
// One quotient bit per cycle; depends on sfs_pkg only for the saturation value.
module sfs_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [23:0] den,
    output logic        done,
    output logic [8:0]  quo
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [23:0] rem_reg;
    logic [23:0] den_reg;
    logic [7:0]  q_reg;
    logic [8:0]  res_reg;
    logic [24:0] shifted;
    logic        fits;
    logic [7:0]  q_next;

    // One restoring step on the partial remainder.
    always_comb begin
        shifted = {rem_reg, 1'b0};
        fits    = shifted >= {1'b0, den_reg};
        q_next  = {q_reg[6:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                den_reg <= den;
                q_reg   <= '0;
                if (num >= {8'd0, den}) begin
                    // Quotient reaches one: saturate at once.
                    res_reg  <= sfs_pkg::INTERP_ONE;
                    done_reg <= 1'b1;
                end else begin
                    rem_reg  <= num[23:0];
                    cnt_reg  <= 4'd8;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg <= fits ? 24'(shifted - {1'b0, den_reg}) : shifted[23:0];
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    res_reg  <= {1'b0, q_next};
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = res_reg;

endmodule

// ===== hw/rtl/sfs_datapath.sv =====
// Datapath of the sprite frame sequencer: frame table memory, playback state,
// configuration registers, tick arithmetic and the output word register.
// Depends on sfs_pkg and sfs_div.
module sfs_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  sfs_pkg::in_word_t s_data,
    input  sfs_pkg::cmd_t     cmd,
    output sfs_pkg::status_t  status,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wr_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sfs_pkg::out_word_t m_data
);

    localparam int FW = sfs_pkg::FRAME_W;
    localparam int CW = sfs_pkg::COUNT_W;
    localparam logic [CW-1:0] MAXF = CW'(sfs_pkg::MAX_FRAMES);

    sfs_pkg::entry_t   mem [sfs_pkg::MAX_FRAMES];
    sfs_pkg::in_word_t item_reg;
    sfs_pkg::entry_t   entry_reg;
    sfs_pkg::out_word_t out_reg;

    logic [CW-1:0]  count_reg;
    logic           loop_reg;
    logic [15:0]    speed_reg;
    logic [FW-1:0]  cur_reg;
    logic [1:0]     pstate_reg;
    logic [31:0]    elapsed_reg;
    logic           iact_reg;
    logic [8:0]     ival_reg;
    logic [FW-1:0]  target_reg;
    logic [31:0]    prod_reg;
    logic [23:0]    delay_reg;
    logic [sfs_pkg::STEP_W-1:0] steps_reg;
    logic           act_reg;
    logic           m_valid_reg;

    logic [CW-1:0]  n_c;
    logic [CW-1:0]  nxt_c;
    logic [CW-1:0]  prev_c;
    logic           chg_c;
    logic           zero_c;
    logic           halt_c;
    logic           clr_c;
    logic [1:0]     pst_c;
    logic [FW-1:0]  tgt_c;
    logic [39:0]    prod_c;
    logic [32:0]    sum_c;
    logic           out_free;
    logic           div_done;
    logic [8:0]     div_quo;
    logic           rd_en;
    logic [FW-1:0]  rd_addr;
    sfs_pkg::entry_t wr_entry;

    // Clip length, neighbor indexes of the current frame, scaled tick time and elapsed sum.
    always_comb begin
        n_c    = (count_reg > MAXF) ? MAXF : count_reg;
        nxt_c  = {1'b0, cur_reg} + CW'(1);
        prev_c = {1'b0, cur_reg} - CW'(1);
        prod_c = item_reg.dt_ms * speed_reg;
        sum_c  = {1'b0, elapsed_reg} + {1'b0, prod_reg};
    end

    // Decode of a non-tick command against the current state.
    always_comb begin
        chg_c  = 1'b0;
        zero_c = 1'b0;
        halt_c = 1'b0;
        clr_c  = 1'b0;
        pst_c  = pstate_reg;
        tgt_c  = cur_reg;
        case (item_reg.mode)
            sfs_pkg::MODE_PLAY: begin
                if (n_c != '0) pst_c = sfs_pkg::ST_PLAYING;
            end
            sfs_pkg::MODE_PAUSE: begin
                if (pstate_reg == sfs_pkg::ST_PLAYING) pst_c = sfs_pkg::ST_PAUSED;
            end
            sfs_pkg::MODE_RESUME: begin
                if (pstate_reg == sfs_pkg::ST_PAUSED) pst_c = sfs_pkg::ST_PLAYING;
            end
            sfs_pkg::MODE_STOP: begin
                halt_c = 1'b1;
            end
            sfs_pkg::MODE_RESET: begin
                halt_c = 1'b1;
                if (n_c != '0) begin
                    chg_c = 1'b1;
                    tgt_c = '0;
                end
            end
            sfs_pkg::MODE_SET: begin
                if ({1'b0, item_reg.frame_index} < n_c) begin
                    zero_c = 1'b1;
                    chg_c  = 1'b1;
                    tgt_c  = item_reg.frame_index;
                end
            end
            sfs_pkg::MODE_NEXT: begin
                if (n_c != '0) begin
                    if (nxt_c >= n_c) begin
                        if (loop_reg) begin
                            zero_c = 1'b1;
                            chg_c  = 1'b1;
                            tgt_c  = '0;
                        end
                    end else begin
                        zero_c = 1'b1;
                        chg_c  = 1'b1;
                        tgt_c  = nxt_c[FW-1:0];
                    end
                end
            end
            sfs_pkg::MODE_PREV: begin
                if (n_c != '0) begin
                    if (cur_reg != '0) begin
                        zero_c = 1'b1;
                        tgt_c  = prev_c[FW-1:0];
                        chg_c  = prev_c < n_c;
                    end else if (loop_reg) begin
                        zero_c = 1'b1;
                        chg_c  = 1'b1;
                        tgt_c  = FW'(n_c - CW'(1));
                    end
                end
            end
            sfs_pkg::MODE_NEWCLIP: begin
                clr_c  = 1'b1;
                halt_c = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        status.tick_go  = (item_reg.mode == sfs_pkg::MODE_TICK)
                          && (pstate_reg == sfs_pkg::ST_PLAYING) && (n_c != '0);
        status.chg      = chg_c;
        status.loop_go  = (steps_reg < sfs_pkg::STEP_W'(sfs_pkg::MAX_STEPS))
                          && (elapsed_reg >= {8'd0, delay_reg});
        status.complete = !(nxt_c < n_c) && !loop_reg;
        status.div_done = div_done;
        status.out_free = out_free;
    end

    // Frame table: one write port, one registered read port.
    assign rd_en   = cmd.rd_tgt || cmd.add;
    assign rd_addr = cmd.add ? cur_reg : target_reg;

    always_comb begin
        wr_entry.delay  = (item_reg.delay_ms == '0) ? 24'd1 : item_reg.delay_ms;
        wr_entry.interp = item_reg.interp_enable;
        wr_entry.kf_on  = item_reg.keyframe_present;
        wr_entry.kf_id  = item_reg.keyframe_id;
        wr_entry.snd_on = item_reg.sound_present;
        wr_entry.snd_id = item_reg.sound_id;
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && item_reg.mode == sfs_pkg::MODE_LOAD) begin
            mem[item_reg.frame_index] <= wr_entry;
        end
        if (rd_en) begin
            entry_reg <= mem[rd_addr];
        end
    end

    // Interpolation factor divider.
    sfs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (elapsed_reg),
        .den     (entry_reg.delay),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Payload registers of the current item and the tick loop.
    always_ff @(posedge aclk) begin
        if (cmd.accept) item_reg <= s_data;
        if (cmd.exec) begin
            target_reg <= tgt_c;
            prod_reg   <= prod_c[39:8];
        end
        if (cmd.add) steps_reg <= '0;
        if (cmd.div_start) begin
            delay_reg <= entry_reg.delay;
            act_reg   <= entry_reg.interp && (nxt_c < n_c);
        end
        if (cmd.emit_chg) delay_reg <= entry_reg.delay;
        if (cmd.step) begin
            steps_reg <= steps_reg + sfs_pkg::STEP_W'(1);
            if (nxt_c < n_c) target_reg <= nxt_c[FW-1:0];
            else target_reg <= '0;
        end
    end

    // Playback state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            loop_reg    <= 1'b0;
            speed_reg   <= 16'd256;
            cur_reg     <= '0;
            pstate_reg  <= sfs_pkg::ST_STOPPED;
            elapsed_reg <= '0;
            iact_reg    <= 1'b0;
            ival_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    sfs_pkg::CFG_FRAME_COUNT: count_reg <= cfg_wr_data[CW-1:0];
                    sfs_pkg::CFG_LOOP_ENABLE: loop_reg  <= cfg_wr_data[0];
                    sfs_pkg::CFG_SPEED:       speed_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (cmd.exec) begin
                pstate_reg <= halt_c ? sfs_pkg::ST_STOPPED : pst_c;
                if (halt_c || zero_c) elapsed_reg <= '0;
                if (halt_c) begin
                    iact_reg <= 1'b0;
                    ival_reg <= '0;
                end
                if (clr_c) cur_reg <= '0;
            end
            if (cmd.add) elapsed_reg <= sum_c[32] ? 32'hFFFF_FFFF : sum_c[31:0];
            if (div_done) begin
                iact_reg <= act_reg;
                ival_reg <= act_reg ? div_quo : 9'd0;
            end
            if (cmd.step) begin
                elapsed_reg <= elapsed_reg - {8'd0, delay_reg};
                if (!(nxt_c < n_c) && !loop_reg) pstate_reg <= sfs_pkg::ST_STOPPED;
            end
            if (cmd.emit_chg) cur_reg <= target_reg;
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_chg || cmd.emit_cmp || cmd.emit_st) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_chg || cmd.emit_cmp || cmd.emit_st) begin
            out_reg.old_frame      <= cur_reg;
            out_reg.play_status    <= pstate_reg;
            out_reg.interpolating  <= iact_reg;
            out_reg.interp_factor  <= ival_reg;
            out_reg.last           <= cmd.emit_st;
            if (cmd.emit_chg) begin
                out_reg.event_kind     <= sfs_pkg::EV_CHANGE;
                out_reg.new_frame      <= target_reg;
                out_reg.keyframe_fire  <= entry_reg.kf_on;
                out_reg.keyframe_value <= entry_reg.kf_on ? entry_reg.kf_id : 16'sd0;
                out_reg.sound_fire     <= entry_reg.snd_on;
                out_reg.sound_number   <= entry_reg.snd_on ? entry_reg.snd_id : 8'd0;
            end else begin
                out_reg.event_kind     <= cmd.emit_cmp ? sfs_pkg::EV_COMPLETE
                                                       : sfs_pkg::EV_STATUS;
                out_reg.new_frame      <= cur_reg;
                out_reg.keyframe_fire  <= 1'b0;
                out_reg.keyframe_value <= 16'sd0;
                out_reg.sound_fire     <= 1'b0;
                out_reg.sound_number   <= 8'd0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== hw/rtl/sfs_ctrl.sv =====
// Controller state machine of the sprite frame sequencer.
// Sequences command decode, table reads, the tick advance loop and result words.
// Depends on sfs_pkg.
module sfs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [3:0]       mode,
    input  sfs_pkg::status_t status,
    output sfs_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EXEC    = 4'd1;
    localparam logic [3:0] S_RDTGT   = 4'd2;
    localparam logic [3:0] S_EMITCHG = 4'd3;
    localparam logic [3:0] S_ADD     = 4'd4;
    localparam logic [3:0] S_DIVST   = 4'd5;
    localparam logic [3:0] S_DIVW    = 4'd6;
    localparam logic [3:0] S_LOOP    = 4'd7;
    localparam logic [3:0] S_EMITCMP = 4'd8;
    localparam logic [3:0] S_EMITST  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       post_reg;
    logic       post_next;
    logic       tick_reg;
    logic       tick_next;

    always_comb begin
        state_next = state_reg;
        post_next  = post_reg;
        tick_next  = tick_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec  = 1'b1;
                tick_next = mode == sfs_pkg::MODE_TICK;
                post_next = 1'b0;
                if (status.tick_go) state_next = S_ADD;
                else if (status.chg) state_next = S_RDTGT;
                else state_next = S_EMITST;
            end
            S_RDTGT: begin
                cmd.rd_tgt = 1'b1;
                state_next = S_EMITCHG;
            end
            S_EMITCHG: begin
                if (status.out_free) begin
                    cmd.emit_chg = 1'b1;
                    state_next   = tick_reg ? S_LOOP : S_EMITST;
                end
            end
            S_ADD: begin
                cmd.add    = 1'b1;
                state_next = S_DIVST;
            end
            S_DIVST: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW: begin
                if (status.div_done) state_next = post_reg ? S_EMITST : S_LOOP;
            end
            S_LOOP: begin
                if (status.loop_go) begin
                    cmd.step   = 1'b1;
                    state_next = status.complete ? S_EMITCMP : S_RDTGT;
                end else begin
                    post_next  = 1'b1;
                    state_next = S_DIVST;
                end
            end
            S_EMITCMP: begin
                if (status.out_free) begin
                    cmd.emit_cmp = 1'b1;
                    state_next   = S_EMITST;
                end
            end
            S_EMITST: begin
                if (status.out_free) begin
                    cmd.emit_st = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            post_reg  <= 1'b0;
            tick_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            post_reg  <= post_next;
            tick_reg  <= tick_next;
        end
    end

endmodule
